// ===== hdl/ipcp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipcp_pkg
// Types, constants and per-character parse functions for the IPv4 network
// text parser.
// ----------------------------------------------------------------------------
package ipcp_pkg;

    localparam int MAX_CHARS = 16;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_SLASH = 8'h2F;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [8:0]  PREFIX_MAX = 9'd32;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_MASK,
        PH_OK,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [7:0]         pend;
        logic               have_pend;
        logic [31:0]        addr_acc;
        logic [1:0]         addr_idx;
        logic [CNT_W-1:0]   addr_cnt;
        logic [31:0]        mask_acc;
        logic [1:0]         mask_idx;
        logic [CNT_W-1:0]   mask_cnt;
        logic               dotted_done;
        logic [5:0]         prefix_len;
        logic               prefix_bad;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
        logic       last_char;
    } t_step;

    typedef struct packed {
        logic        ok;
        logic [31:0] net_address;
        logic [31:0] net_mask;
    } t_res;

    localparam t_state ST_RESET = '{
        phase:       PH_ADDR,
        pend:        8'h00,
        have_pend:   1'b0,
        addr_acc:    32'h0,
        addr_idx:    2'd3,
        addr_cnt:    '0,
        mask_acc:    32'h0,
        mask_idx:    2'd3,
        mask_cnt:    '0,
        dotted_done: 1'b0,
        prefix_len:  6'd0,
        prefix_bad:  1'b0
    };

    function automatic logic is_dec(logic [7:0] c);
        return (c >= CH_ZERO) && (c < CH_COLON);
    endfunction

    // octet = octet * 10 + digit, modulo 256
    function automatic logic [31:0] add_digit(logic [31:0] acc, logic [1:0] idx,
                                              logic [7:0] c);
        logic [31:0] r;
        logic [7:0]  oct;
        logic [7:0]  d;
        r   = acc;
        d   = 8'(c - CH_ZERO);
        oct = acc[{idx, 3'b000} +: 8];
        oct = 8'({oct[4:0], 3'b000}) + 8'({oct[6:0], 1'b0}) + d;
        r[{idx, 3'b000} +: 8] = oct;
        return r;
    endfunction

    function automatic t_state handle(t_state s, logic [7:0] c, logic [7:0] nxt);
        t_state     r;
        logic       ends;
        logic [8:0] v;
        r    = s;
        ends = (c == CH_DOT) || (nxt == CH_NUL) || (nxt == CH_SLASH);
        v    = (9'(s.prefix_len) << 3) + (9'(s.prefix_len) << 1)
             + 9'(8'(c - CH_ZERO));
        case (s.phase)
            PH_ADDR: begin
                if (c == CH_SLASH || 32'(s.addr_cnt) >= MAX_CHARS) begin
                    r.phase = PH_FAIL;
                end else begin
                    if (is_dec(c)) begin
                        r.addr_acc = add_digit(s.addr_acc, s.addr_idx, c);
                    end
                    r.addr_cnt = s.addr_cnt + 1'b1;
                    if (ends) begin
                        if (s.addr_idx == 2'd0) begin
                            if (nxt == CH_SLASH) begin
                                r.phase = PH_MASK;
                            end else begin
                                r.mask_acc = ALL_ONES;
                                r.phase    = PH_OK;
                            end
                        end else begin
                            r.addr_idx = s.addr_idx - 2'd1;
                        end
                    end
                end
            end
            PH_MASK: begin
                if (!s.dotted_done && 32'(s.mask_cnt) < MAX_CHARS) begin
                    if (c == CH_SLASH) begin
                        r.mask_cnt = CNT_W'(MAX_CHARS);
                    end else begin
                        if (is_dec(c)) begin
                            r.mask_acc = add_digit(s.mask_acc, s.mask_idx, c);
                        end
                        r.mask_cnt = s.mask_cnt + 1'b1;
                        if (ends) begin
                            if (s.mask_idx == 2'd0) begin
                                r.dotted_done = 1'b1;
                            end else begin
                                r.mask_idx = s.mask_idx - 2'd1;
                            end
                        end
                    end
                end
                if (!s.prefix_bad) begin
                    if (is_dec(c) && v <= PREFIX_MAX) begin
                        r.prefix_len = v[5:0];
                    end else begin
                        r.prefix_bad = 1'b1;
                    end
                end
                if (r.dotted_done) begin
                    r.phase = PH_OK;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_state finish(t_state s);
        t_state r;
        r = s;
        case (s.phase)
            PH_ADDR: begin
                r.phase = PH_FAIL;
            end
            PH_MASK: begin
                if (s.prefix_bad) begin
                    r.mask_acc = ALL_ONES;
                end else begin
                    r.mask_acc = ~(ALL_ONES >> s.prefix_len);
                end
                r.phase = PH_OK;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // one character with one character of lookahead; NUL is the end of text
    function automatic t_state feed(t_state s, logic [7:0] c);
        t_state r;
        t_state h;
        logic   done;
        r    = s;
        h    = s;
        done = 1'b0;
        if (s.phase == PH_ADDR || s.phase == PH_MASK) begin
            if (s.have_pend) begin
                r.have_pend = 1'b0;
                h = handle(r, s.pend, c);
                done = (s.phase == PH_ADDR && h.phase == PH_MASK)
                    || h.phase == PH_OK || h.phase == PH_FAIL;
                r = h;
            end
            if (!done) begin
                if (c == CH_NUL) begin
                    r = finish(r);
                end else begin
                    r.pend      = c;
                    r.have_pend = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/ipcp_in_if.sv =====
// ----------------------------------------------------------------------------
// ipcp_in_if
// Character request channel: one text character per request.
// ----------------------------------------------------------------------------
interface ipcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

// ===== hdl/ipcp_out_if.sv =====
// ----------------------------------------------------------------------------
// ipcp_out_if
// Result request channel: one parsed network per text.
// ----------------------------------------------------------------------------
interface ipcp_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] net_address;
    logic [31:0] net_mask;

    modport source (output valid, output ok, output net_address, output net_mask,
                    input ready);
    modport sink   (input valid, input ok, input net_address, input net_mask,
                    output ready);
endinterface

// ===== hdl/ipcp_core.sv =====
// ----------------------------------------------------------------------------
// ipcp_core
// Parse state register and the per-character update; on the last character
// it also closes the text and forms the result.
// ----------------------------------------------------------------------------
module ipcp_core
    import ipcp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_step i_step,
    output t_res  o_res
);

    t_state r_state;
    t_state n_state;
    t_state s_char;
    t_state s_end;

    always_comb begin
        s_char  = feed(r_state, i_step.ch);
        s_end   = feed(s_char, CH_NUL);
        n_state = i_step.last_char ? ST_RESET : s_char;
        o_res.ok          = (s_end.phase == PH_OK);
        o_res.net_address = o_res.ok ? s_end.addr_acc : 32'h0;
        o_res.net_mask    = o_res.ok ? s_end.mask_acc : 32'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else if (i_step.valid) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.valid && i_step.last_char |=>
            r_state.phase == PH_ADDR && !r_state.have_pend && r_state.addr_cnt == '0)
        else $error("parse state not cleared after end of text");
    a_addr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_state.addr_cnt) <= MAX_CHARS)
        else $error("address character count overrun");
    a_mask_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_state.mask_cnt) <= MAX_CHARS)
        else $error("mask character count overrun");
    a_mask_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_MASK |-> r_state.addr_idx == 2'd0)
        else $error("mask phase entered before four address octets");
`endif

endmodule

// ===== hdl/ipv4_cidr_text_parser.sv =====
// ----------------------------------------------------------------------------
// ipv4_cidr_text_parser
// IPv4 dotted-quad parser with optional /mask, one character per request.
// ----------------------------------------------------------------------------
// Characters stream in on i_req, one per cycle unless a stalled result holds
// back a last character, with last_char on the final one; a NUL character
// ends the text early. One result comes out on o_rsp for each text: ok, the
// address with the first octet in bits 31..24, and the mask (dotted quad,
// prefix length, or all ones); both are zero when ok is low. The last
// character of a text passes the input register and the decimal accumulate,
// and its result is held in the result register until it is taken. A stalled
// result holds back only the next last character, not the ones before it.
// ----------------------------------------------------------------------------
module ipv4_cidr_text_parser
    import ipcp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipcp_in_if.sink       i_req,
    ipcp_out_if.source    o_rsp
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;
    logic       r_out_valid;
    t_res       r_out;
    logic       advance;
    logic       in_ready;
    t_step      step;
    t_res       res;

    assign advance  = r_in_valid && (!r_in_last || !r_out_valid || o_rsp.ready);
    assign in_ready = !r_in_valid || advance;

    assign step.valid     = advance;
    assign step.ch        = r_in_ch;
    assign step.last_char = r_in_last;

    ipcp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_ch   <= i_req.ch;
            r_in_last <= i_req.last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= res;
        end
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.net_address = r_out.net_address;
    assign o_rsp.net_mask    = r_out.net_mask;

`ifndef SYNTH
    a_last_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && r_out_valid && !o_rsp.ready |=>
            r_in_valid && r_in_last && r_out_valid)
        else $error("end of text lost while result stalled");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.ok |-> r_out.net_address == 32'h0 && r_out.net_mask == 32'h0)
        else $error("failed parse carries nonzero fields");
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_last && r_out_valid && o_rsp.ready |=> !r_out_valid)
        else $error("result raised without end of text");
`endif

endmodule
